// File: hdl/tsas_pkg.sv
// Package: shared types and constants for the touch sample average and scale block.
`default_nettype none
package tsas_pkg;

    localparam int RAW_W = 16;
    localparam int SPAN_W = 12;
    localparam int DEN_W = 16;
    localparam int DIV_W = 28;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_RAW_X_MIN = 3'd0;
    localparam logic [IDX_W-1:0] REG_RAW_X_MAX = 3'd1;
    localparam logic [IDX_W-1:0] REG_RAW_Y_MIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_RAW_Y_MAX = 3'd3;
    localparam logic [IDX_W-1:0] REG_SPAN_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_SPAN_Y = 3'd5;

    localparam logic [RAW_W-1:0] RST_RAW_X_MIN = 16'd1500;
    localparam logic [RAW_W-1:0] RST_RAW_X_MAX = 16'd31000;
    localparam logic [RAW_W-1:0] RST_RAW_Y_MIN = 16'd3276;
    localparam logic [RAW_W-1:0] RST_RAW_Y_MAX = 16'd30110;
    localparam logic [SPAN_W-1:0] RST_SPAN_X = 12'd240;
    localparam logic [SPAN_W-1:0] RST_SPAN_Y = 12'd320;

    typedef struct packed {
        logic [RAW_W-1:0] raw_x_min;
        logic [RAW_W-1:0] raw_x_max;
        logic [RAW_W-1:0] raw_y_min;
        logic [RAW_W-1:0] raw_y_max;
        logic [SPAN_W-1:0] span_x;
        logic [SPAN_W-1:0] span_y;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_CLAMP,
        ST_MUL,
        ST_SCALE,
        ST_SCALE_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic avg;
        logic div_start;
        logic clamp;
        logic mul;
        logic finish;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic pen;
        logic last;
        logic div_idle;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: hdl/touch_sample_average_scale.sv
// Top level: calibration registers and stream ports of the touch average and scale block.
// A pen-down word that does not finish a run is only accumulated; the next word is taken next cycle.
// A word that finishes a run of SAMPLES goes through the average multiply, clamp, scale multiply,
// 28-bit serial divide and emit states to the output register; the next word is taken after emit.
// A pen-up word goes through emit to the output register; emit waits while that register is full.
// Synchronous active-low reset clears sums, count, state and output valid and loads defaults.
`default_nettype none
module touch_sample_average_scale #(
    parameter int SAMPLES = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // sample_x[15:0], sample_y[31:16]
    input  wire         i_s_tuser,   // pen_down
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,   // pos_x[11:0], pos_y[23:12]
    output logic        o_m_tuser,   // touched
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data
);
    import tsas_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic [SPAN_W-1:0] pos_x, pos_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raw_x_min <= RST_RAW_X_MIN;
            r_cfg.raw_x_max <= RST_RAW_X_MAX;
            r_cfg.raw_y_min <= RST_RAW_Y_MIN;
            r_cfg.raw_y_max <= RST_RAW_Y_MAX;
            r_cfg.span_x <= RST_SPAN_X;
            r_cfg.span_y <= RST_SPAN_Y;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RAW_X_MIN: r_cfg.raw_x_min <= i_cfg_data;
                REG_RAW_X_MAX: r_cfg.raw_x_max <= i_cfg_data;
                REG_RAW_Y_MIN: r_cfg.raw_y_min <= i_cfg_data;
                REG_RAW_Y_MAX: r_cfg.raw_y_max <= i_cfg_data;
                REG_SPAN_X:    r_cfg.span_x <= i_cfg_data[SPAN_W-1:0];
                REG_SPAN_Y:    r_cfg.span_y <= i_cfg_data[SPAN_W-1:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    tsas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tsas_dp #(
        .SAMPLES (SAMPLES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_pen      (i_s_tuser),
        .i_sample_x (i_s_tdata[15:0]),
        .i_sample_y (i_s_tdata[31:16]),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_touched  (o_m_tuser),
        .o_pos_x    (pos_x),
        .o_pos_y    (pos_y)
    );

    assign o_m_tdata = {pos_y, pos_x};

endmodule
`default_nettype wire

// File: hdl/tsas_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module tsas_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  [tsas_pkg::DIV_W-1:0] i_num,
    input  wire  [tsas_pkg::DEN_W-1:0] i_den,
    output logic                       o_busy,
    output logic [tsas_pkg::DIV_W-1:0] o_quo
);
    import tsas_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0] rem_sh;
    logic [DEN_W+1:0] diff;

    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign diff = {1'b0, rem_sh} - {2'b00, r_den};
    assign o_busy = (r_cnt != '0);
    assign o_quo = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DIV_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (o_busy) begin
            if (!diff[DEN_W+1]) begin
                r_rem <= diff[DEN_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DEN_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/tsas_dp.sv
// Datapath: sample accumulators, average multiply, clamp, scale multiply, dividers and output register.
`default_nettype none
module tsas_dp #(
    parameter int SAMPLES = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  tsas_pkg::t_cfg        i_cfg,
    input  wire  tsas_pkg::t_cmd        i_cmd,
    output tsas_pkg::t_sts              o_sts,
    input  wire                         i_pen,
    input  wire  [tsas_pkg::RAW_W-1:0]  i_sample_x,
    input  wire  [tsas_pkg::RAW_W-1:0]  i_sample_y,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic                        o_touched,
    output logic [tsas_pkg::SPAN_W-1:0] o_pos_x,
    output logic [tsas_pkg::SPAN_W-1:0] o_pos_y
);
    import tsas_pkg::*;

    localparam int SUM_W = RAW_W + $clog2(SAMPLES);
    localparam int CNT_W = $clog2(SAMPLES);
    localparam int PROD_W = RAW_W + SPAN_W;
    localparam int AVG_SH = SUM_W + $clog2(SAMPLES);
    localparam int RCP_W = SUM_W + 2;
    localparam int AVG_W = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] AVG_RCP = RCP_W'(((1 << AVG_SH) + SAMPLES - 1) / SAMPLES);

    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_sum_x, r_sum_y, r_tot_x, r_tot_y;
    logic [SUM_W-1:0] add_x, add_y;
    logic [AVG_W-1:0] avg_prod_x, avg_prod_y;
    logic [RAW_W-1:0] r_avg_x, r_avg_y;
    logic [RAW_W-1:0] r_off_x, r_off_y;
    logic [PROD_W-1:0] r_prod_x, r_prod_y;
    logic r_ok_x, r_ok_y;
    logic r_res_touched;
    logic [SPAN_W-1:0] r_res_x, r_res_y;
    logic r_out_valid;
    logic r_out_touched;
    logic [SPAN_W-1:0] r_out_x, r_out_y;
    logic [DIV_W-1:0] num_x, num_y, quo_x, quo_y;
    logic [DEN_W-1:0] den_x, den_y;
    logic busy_x, busy_y;
    logic [RAW_W-1:0] cx, cy;
    logic last;

    assign add_x = r_sum_x + SUM_W'(i_sample_x);
    assign add_y = r_sum_y + SUM_W'(i_sample_y);
    assign last = (r_count == CNT_W'(SAMPLES - 1));

    assign o_sts.pen = i_pen;
    assign o_sts.last = last;
    assign o_sts.div_idle = !busy_x && !busy_y;
    assign o_sts.out_free = !r_out_valid || i_ready;

    // accumulate while pen is down, clear on pen up or full run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if (i_cmd.accept) begin
            if (!i_pen || last) begin
                r_count <= '0;
                r_sum_x <= '0;
                r_sum_y <= '0;
            end else begin
                r_count <= r_count + 1'b1;
                r_sum_x <= add_x;
                r_sum_y <= add_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_pen && last) begin
            r_tot_x <= add_x;
            r_tot_y <= add_y;
        end
    end

    // divide by SAMPLES with a reciprocal multiply
    assign avg_prod_x = AVG_W'(r_tot_x) * AVG_W'(AVG_RCP);
    assign avg_prod_y = AVG_W'(r_tot_y) * AVG_W'(AVG_RCP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.avg) begin
            r_avg_x <= avg_prod_x[AVG_SH +: RAW_W];
            r_avg_y <= avg_prod_y[AVG_SH +: RAW_W];
        end
    end

    assign num_x = DIV_W'(r_prod_x);
    assign num_y = DIV_W'(r_prod_y);
    assign den_x = i_cfg.raw_x_max - i_cfg.raw_x_min;
    assign den_y = i_cfg.raw_y_max - i_cfg.raw_y_min;

    tsas_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num_x),
        .i_den   (den_x),
        .o_busy  (busy_x),
        .o_quo   (quo_x)
    );

    tsas_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num_y),
        .i_den   (den_y),
        .o_busy  (busy_y),
        .o_quo   (quo_y)
    );

    // floor first, then ceiling
    always_comb begin
        cx = (r_avg_x < i_cfg.raw_x_min) ? i_cfg.raw_x_min : r_avg_x;
        cx = (cx > i_cfg.raw_x_max) ? i_cfg.raw_x_max : cx;
        cy = (r_avg_y < i_cfg.raw_y_min) ? i_cfg.raw_y_min : r_avg_y;
        cy = (cy > i_cfg.raw_y_max) ? i_cfg.raw_y_max : cy;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clamp) begin
            r_off_x <= cx - i_cfg.raw_x_min;
            r_off_y <= cy - i_cfg.raw_y_min;
            r_ok_x <= (i_cfg.raw_x_max > i_cfg.raw_x_min);
            r_ok_y <= (i_cfg.raw_y_max > i_cfg.raw_y_min);
        end
        if (i_cmd.mul) begin
            r_prod_x <= PROD_W'(r_off_x) * PROD_W'(i_cfg.span_x);
            r_prod_y <= PROD_W'(r_off_y) * PROD_W'(i_cfg.span_y);
        end
    end

    // mirror X; empty window gives zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !i_pen) begin
            r_res_touched <= 1'b0;
            r_res_x <= '0;
            r_res_y <= '0;
        end else if (i_cmd.finish) begin
            r_res_touched <= 1'b1;
            r_res_x <= r_ok_x ? (i_cfg.span_x - quo_x[SPAN_W-1:0]) : '0;
            r_res_y <= r_ok_y ? quo_y[SPAN_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_touched <= r_res_touched;
            r_out_x <= r_res_x;
            r_out_y <= r_res_y;
        end
    end

    assign o_valid = r_out_valid;
    assign o_touched = r_out_touched;
    assign o_pos_x = r_out_x;
    assign o_pos_y = r_out_y;

endmodule
`default_nettype wire

// File: hdl/tsas_ctrl.sv
// Controller: state machine sequencing accumulate, average, clamp, scale and emit.
`default_nettype none
module tsas_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  wire  tsas_pkg::t_sts i_sts,
    output tsas_pkg::t_cmd  o_cmd
);
    import tsas_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (!i_sts.pen) begin
                        n_state = ST_EMIT;
                    end else if (i_sts.last) begin
                        n_state = ST_AVG;
                    end
                end
            end
            ST_AVG:        n_state = ST_CLAMP;
            ST_CLAMP:      n_state = ST_MUL;
            ST_MUL:        n_state = ST_SCALE;
            ST_SCALE:      n_state = ST_SCALE_WAIT;
            ST_SCALE_WAIT: begin
                if (i_sts.div_idle) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                o_cmd.accept = i_valid;
            end
            ST_AVG:        o_cmd.avg = 1'b1;
            ST_CLAMP:      o_cmd.clamp = 1'b1;
            ST_MUL:        o_cmd.mul = 1'b1;
            ST_SCALE:      o_cmd.div_start = 1'b1;
            ST_SCALE_WAIT: o_cmd.finish = i_sts.div_idle;
            ST_EMIT:       o_cmd.load_out = i_sts.out_free;
            default:       o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Testbench: streams touch sample words into the average and scale block and checks each position.
`timescale 1ns / 1ps
module tb_top;
    import tsas_pkg::*;

    localparam int N_AVG = 16;
    localparam int SUM_W = RAW_W + $clog2(N_AVG);
    localparam int CNT_W = $clog2(N_AVG) + 1;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 80;
    localparam int DIR_N = 22;
    localparam int PHASES = 10;
    localparam int PHASE_WORDS = 53;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic              touched;
        logic [SPAN_W-1:0] pos_x;
        logic [SPAN_W-1:0] pos_y;
    } t_touch_pos;

    typedef struct packed {
        logic             pen;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
        logic             known;
        t_touch_pos       want;
    } t_sample_row;

    logic             clk;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [31:0]      s_tdata  = '0;
    logic             s_tuser  = 1'b0;
    logic             m_tready = 1'b0;
    logic             cfg_we   = 1'b0;
    logic [IDX_W-1:0] cfg_idx  = '0;
    logic [RAW_W-1:0] cfg_data = '0;
    wire              s_tready;
    wire              m_tvalid;
    wire  [23:0]      m_tdata;
    wire              m_tuser;

    logic [RAW_W-1:0]  cal_x_min  = RST_RAW_X_MIN;
    logic [RAW_W-1:0]  cal_x_max  = RST_RAW_X_MAX;
    logic [RAW_W-1:0]  cal_y_min  = RST_RAW_Y_MIN;
    logic [RAW_W-1:0]  cal_y_max  = RST_RAW_Y_MAX;
    logic [SPAN_W-1:0] cal_span_x = RST_SPAN_X;
    logic [SPAN_W-1:0] cal_span_y = RST_SPAN_Y;
    logic [CNT_W-1:0]  run_count  = '0;
    logic [SUM_W-1:0]  run_sum_x  = '0;
    logic [SUM_W-1:0]  run_sum_y  = '0;

    t_touch_pos pos_expected_q[$];
    int         err_count  = 0;
    int         res_seen   = 0;
    int         idle_count = 0;
    bit         no_idle    = 1'b0;

    touch_sample_average_scale #(.SAMPLES(N_AVG)) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // sample_x[15:0], sample_y[31:16]
        .i_s_tuser  (s_tuser),   // pen_down
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // pos_x[11:0], pos_y[23:12]
        .o_m_tuser  (m_tuser),   // touched
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [SPAN_W-1:0] scale_axis_pos(input logic [RAW_W-1:0] avg,
                                                          input logic [RAW_W-1:0] lo,
                                                          input logic [RAW_W-1:0] hi,
                                                          input logic [SPAN_W-1:0] span);
        logic [RAW_W-1:0] v;
        logic [DIV_W-1:0] num;
        v = avg;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        if (hi <= lo) return '0;
        num = v - lo;
        num = num * span;
        return num / (hi - lo);
    endfunction

    function automatic bit predict_touch(input logic pen, input logic [RAW_W-1:0] sx,
                                         input logic [RAW_W-1:0] sy, output t_touch_pos pos);
        logic [RAW_W-1:0] avg_x;
        logic [RAW_W-1:0] avg_y;
        pos = '0;
        if (!pen) begin
            run_count = '0;
            run_sum_x = '0;
            run_sum_y = '0;
            return 1'b1;
        end
        run_sum_x = run_sum_x + sx;
        run_sum_y = run_sum_y + sy;
        run_count = run_count + 1'b1;
        if (run_count < N_AVG) return 1'b0;
        avg_x = run_sum_x / N_AVG;
        avg_y = run_sum_y / N_AVG;
        run_count = '0;
        run_sum_x = '0;
        run_sum_y = '0;
        pos.touched = 1'b1;
        if (cal_x_max > cal_x_min)
            pos.pos_x = cal_span_x - scale_axis_pos(avg_x, cal_x_min, cal_x_max, cal_span_x);
        pos.pos_y = scale_axis_pos(avg_y, cal_y_min, cal_y_max, cal_span_y);
        return 1'b1;
    endfunction

    function automatic logic [RAW_W-1:0] near_center(input int center);
        int v;
        v = center + $urandom_range(0, 512) - 256;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[RAW_W-1:0];
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RAW_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_RAW_X_MIN: cal_x_min  = data;
            REG_RAW_X_MAX: cal_x_max  = data;
            REG_RAW_Y_MIN: cal_y_min  = data;
            REG_RAW_Y_MAX: cal_y_max  = data;
            REG_SPAN_X:    cal_span_x = data[SPAN_W-1:0];
            REG_SPAN_Y:    cal_span_y = data[SPAN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_calibration(input logic [RAW_W-1:0] x_lo, input logic [RAW_W-1:0] x_hi,
                                    input logic [RAW_W-1:0] y_lo, input logic [RAW_W-1:0] y_hi,
                                    input logic [SPAN_W-1:0] w, input logic [SPAN_W-1:0] h);
        logic [RAW_W-SPAN_W-1:0] pad_w;
        logic [RAW_W-SPAN_W-1:0] pad_h;
        pad_w = $urandom;
        pad_h = $urandom;
        write_reg(REG_RAW_X_MIN, x_lo);
        write_reg(REG_RAW_X_MAX, x_hi);
        write_reg(REG_RAW_Y_MIN, y_lo);
        write_reg(REG_RAW_Y_MAX, y_hi);
        write_reg(REG_SPAN_X, {pad_w, w});
        write_reg(REG_SPAN_Y, {pad_h, h});
        cfg_we <= 1'b0;
    endtask

    task automatic send_word(input logic pen, input logic [RAW_W-1:0] sx,
                             input logic [RAW_W-1:0] sy, input logic known,
                             input t_touch_pos want);
        int gap;
        t_touch_pos pos;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sy, sx};
        s_tuser  <= pen;
        do @(posedge clk); while (!s_tready);
        if (predict_touch(pen, sx, sy, pos))
            pos_expected_q.push_back(known ? want : pos);
    endtask

    task automatic drain_and_settle();
        while (pos_expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : result_sink
        int stall;
        t_touch_pos got;
        t_touch_pos want;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got = {m_tuser, m_tdata[SPAN_W-1:0], m_tdata[2*SPAN_W-1:SPAN_W]};
            res_seen++;
            if (pos_expected_q.size() == 0) begin
                if (err_count < REPORT_MAX)
                    $display("result %0d unexpected: touched %0b pos_x %0d pos_y %0d",
                             res_seen, got.touched, got.pos_x, got.pos_y);
                err_count++;
            end else begin
                want = pos_expected_q.pop_front();
                if (got.touched !== want.touched || got.pos_x !== want.pos_x ||
                    got.pos_y !== want.pos_y) begin
                    if (err_count < REPORT_MAX)
                        $display("result %0d: exp touched %0b x %0d y %0d, got %0b x %0d y %0d",
                                 res_seen, want.touched, want.pos_x, want.pos_y,
                                 got.touched, got.pos_x, got.pos_y);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        t_sample_row rows [DIR_N];
        int n;
        int ph;
        int run_mode;
        int cx;
        int cy;
        logic pen;
        logic [RAW_W-1:0] sx;
        logic [RAW_W-1:0] sy;
        logic [RAW_W-1:0] lo_x;
        logic [RAW_W-1:0] lo_y;

        rows[0] = {1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 25'd0};
        for (n = 1; n <= N_AVG; n++)
            rows[n] = {1'b1, (n % 2) ? 16'hFFFF : 16'h0000, (n % 2) ? 16'h0000 : 16'hFFFF,
                       1'b0, 25'd0};
        // half full-scale average lands above both ceilings: x mirrors to 0, y hits the span
        rows[N_AVG].known = 1'b1;
        rows[N_AVG].want  = {1'b1, 12'd0, 12'd320};
        rows[17] = {1'b1, 16'h1234, 16'hEDCB, 1'b0, 25'd0};
        rows[18] = {1'b1, 16'h8000, 16'h7FFF, 1'b0, 25'd0};
        rows[19] = {1'b1, 16'h0001, 16'hFFFE, 1'b0, 25'd0};
        rows[20] = {1'b0, 16'h0000, 16'h0000, 1'b1, 25'd0};
        rows[21] = {1'b0, 16'hA5A5, 16'h5A5A, 1'b1, 25'd0};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIR_N; n++)
            send_word(rows[n].pen, rows[n].raw_x, rows[n].raw_y, rows[n].known, rows[n].want);

        for (ph = 0; ph < PHASES; ph++) begin
            s_tvalid <= 1'b0;
            drain_and_settle();
            case (ph)
                0: load_calibration(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 12'hFFF, 12'hFFF);
                1: load_calibration(16'd40000, 16'd1000, 16'd50000, 16'd20000, 12'd240, 12'd320);
                2: load_calibration(16'd12345, 16'd12345, 16'd0, 16'd0, 12'hFFF, 12'd100);
                3: load_calibration(16'd1000, 16'd60000, 16'd2000, 16'd50000, 12'd0, 12'd0);
                4: load_calibration(16'd30000, 16'd30001, 16'd32767, 16'd32768, 12'hFFF, 12'hFFF);
                9: load_calibration(RST_RAW_X_MIN, RST_RAW_X_MAX, RST_RAW_Y_MIN, RST_RAW_Y_MAX,
                                    RST_SPAN_X, RST_SPAN_Y);
                default: begin
                    lo_x = $urandom_range(0, 30000);
                    lo_y = $urandom_range(0, 30000);
                    load_calibration(lo_x, $urandom_range(lo_x + 1, 65535),
                                     lo_y, $urandom_range(lo_y + 1, 65535),
                                     $urandom_range(1, 4095), $urandom_range(1, 4095));
                end
            endcase
            no_idle = (ph % 3 == 1);
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (run_count == 0) begin
                    run_mode = $urandom_range(0, 3);
                    cx = $urandom_range(0, 65535);
                    cy = $urandom_range(0, 65535);
                end
                pen = ($urandom_range(0, 99) >= 3);
                case (run_mode)
                    0: begin
                        sx = $urandom;
                        sy = $urandom;
                    end
                    3: begin
                        sx = cx[0] ? 16'hFFFF : 16'h0000;
                        sy = cy[0] ? 16'hFFFF : 16'h0000;
                    end
                    default: begin
                        sx = near_center(cx);
                        sy = near_center(cy);
                    end
                endcase
                send_word(pen, sx, sy, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        drain_and_settle();
        if (err_count == 0 && pos_expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
